>>> hw/rtl/psrr_pkg.sv
package psrr_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PID_W = 4;

	typedef logic [1:0] slot_st_t;

	localparam slot_st_t ST_UNUSED = 2'd0;
	localparam slot_st_t ST_RUN    = 2'd1;
	localparam slot_st_t ST_EXITED = 2'd2;

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_EXIT   = 2'd1;
	localparam logic [1:0] MODE_YIELD  = 2'd2;
	localparam logic [1:0] MODE_WAIT   = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NOTASK  = 2'd2;
	localparam logic [1:0] STAT_PENDING = 2'd3;

	typedef struct packed {
		logic [1:0]       mode;
		logic [PID_W-1:0] target_pid;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PID_W-1:0] new_pid;
		logic             switched;
		logic [PID_W-1:0] current_pid;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	// idle slot carries id 0, slot s>0 carries id s+1
	function automatic logic [PID_W-1:0] slot_id(input logic [SLOT_W-1:0] s);
		logic [SLOT_W:0] w;
		w = {1'b0, s} + {{SLOT_W{1'b0}}, 1'b1};
		if (s == '0)
			return '0;
		return PID_W'(w);
	endfunction

endpackage

>>> hw/rtl/psrr_ctrl.sv
module psrr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output psrr_pkg::cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item accepted but not busy");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done) else $error("execute cycle gave no result");

endmodule

>>> hw/rtl/psrr_dp.sv
module psrr_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  psrr_pkg::cmd_t  cmd,
	input  psrr_pkg::req_t  req,
	output psrr_pkg::rsp_t  rsp
);

	psrr_pkg::slot_st_t slot_state_q [psrr_pkg::SLOTS];
	psrr_pkg::slot_st_t slot_state_d [psrr_pkg::SLOTS];
	logic [psrr_pkg::SLOT_W-1:0] current_q;
	logic [psrr_pkg::SLOT_W-1:0] current_d;
	psrr_pkg::req_t req_q;
	psrr_pkg::rsp_t rsp_q;
	psrr_pkg::rsp_t rsp_d;

	logic free_hit, hi_hit, lo_hit, match_hit;
	logic [psrr_pkg::SLOT_W-1:0] free_idx, hi_idx, lo_idx, match_idx, yield_idx;

	// parallel priority searches over the slot table
	always_comb begin
		free_hit  = 1'b0;
		hi_hit    = 1'b0;
		lo_hit    = 1'b0;
		match_hit = 1'b0;
		free_idx  = '0;
		hi_idx    = '0;
		lo_idx    = '0;
		match_idx = '0;
		for (int i = 0; i < psrr_pkg::SLOTS; i++) begin
			if (!free_hit && slot_state_q[i] == psrr_pkg::ST_UNUSED) begin
				free_hit = 1'b1;
				free_idx = psrr_pkg::SLOT_W'(i);
			end
			if (!hi_hit && i > int'(current_q) && slot_state_q[i] == psrr_pkg::ST_RUN) begin
				hi_hit = 1'b1;
				hi_idx = psrr_pkg::SLOT_W'(i);
			end
			if (!lo_hit && i != 0 && i <= int'(current_q)
					&& slot_state_q[i] == psrr_pkg::ST_RUN) begin
				lo_hit = 1'b1;
				lo_idx = psrr_pkg::SLOT_W'(i);
			end
			if (!match_hit && slot_state_q[i] != psrr_pkg::ST_UNUSED
					&& psrr_pkg::slot_id(psrr_pkg::SLOT_W'(i)) == req_q.target_pid) begin
				match_hit = 1'b1;
				match_idx = psrr_pkg::SLOT_W'(i);
			end
		end
		yield_idx = hi_hit ? hi_idx : (lo_hit ? lo_idx : '0);
	end

	always_comb begin
		slot_state_d = slot_state_q;
		current_d    = current_q;
		rsp_d.status   = psrr_pkg::STAT_OK;
		rsp_d.new_pid  = '0;
		rsp_d.switched = 1'b0;
		unique case (req_q.mode)
			psrr_pkg::MODE_CREATE: begin
				if (free_hit) begin
					slot_state_d[free_idx] = psrr_pkg::ST_RUN;
					rsp_d.new_pid = psrr_pkg::slot_id(free_idx);
				end else begin
					rsp_d.status = psrr_pkg::STAT_FULL;
				end
			end
			psrr_pkg::MODE_EXIT: begin
				slot_state_d[current_q] = psrr_pkg::ST_EXITED;
			end
			psrr_pkg::MODE_YIELD: begin
				current_d = yield_idx;
				rsp_d.switched = (yield_idx != current_q);
			end
			psrr_pkg::MODE_WAIT: begin
				if (!match_hit) begin
					rsp_d.status = psrr_pkg::STAT_NOTASK;
				end else if (slot_state_q[match_idx] == psrr_pkg::ST_EXITED) begin
					slot_state_d[match_idx] = psrr_pkg::ST_UNUSED;
				end else begin
					current_d = yield_idx;
					rsp_d.switched = (yield_idx != current_q);
					rsp_d.status = psrr_pkg::STAT_PENDING;
				end
			end
			default: begin
				rsp_d.status = psrr_pkg::STAT_OK;
			end
		endcase
		rsp_d.current_pid = psrr_pkg::slot_id(current_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psrr_pkg::SLOTS; i++)
				slot_state_q[i] <= (i == 0) ? psrr_pkg::ST_RUN : psrr_pkg::ST_UNUSED;
			current_q <= '0;
		end else if (cmd.exec) begin
			slot_state_q <= slot_state_d;
			current_q    <= current_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.exec)
			rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(current_q) < psrr_pkg::SLOTS) else $error("current slot out of range");
	a_exit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q.mode == psrr_pkg::MODE_EXIT)
		|=> slot_state_q[$past(current_q)] == psrr_pkg::ST_EXITED)
		else $error("exit did not mark current slot");

endmodule

>>> hw/rtl/process_slot_round_robin_scheduler.sv
// channel  | handshake        | payload
// request  | start / busy     | req  (mode, target_pid)
// result   | done (1 cycle)   | rsp  (status, new_pid, switched, current_pid)
//
// The request is latched first; the slot table is then searched and updated,
// and done pulses in the cycle after that.
// A new item may be accepted in the same cycle that done is high.
// Reset: slot 0 runnable, all other slots unused, slot 0 current.
// The result is shown for one cycle only; the receiver cannot stall.
module process_slot_round_robin_scheduler (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  psrr_pkg::req_t  req,
	output logic            done,
	output psrr_pkg::rsp_t  rsp
);

	psrr_pkg::cmd_t cmd;

	psrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	psrr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> tb/sv/process_slot_round_robin_scheduler_test.sv
module process_slot_round_robin_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 500;

	class sched_checker;
		psrr_pkg::slot_st_t slot_st [psrr_pkg::SLOTS];
		int                 cur_slot;
		psrr_pkg::rsp_t     pending_rsp_q [$];
		int                 fail_count;

		function new();
			for (int s = 0; s < psrr_pkg::SLOTS; s++)
				slot_st[s] = psrr_pkg::ST_UNUSED;
			slot_st[0] = psrr_pkg::ST_RUN;
			cur_slot = 0;
			fail_count = 0;
		endfunction

		function logic [psrr_pkg::PID_W-1:0] pid_of(int s);
			if (s == 0)
				return '0;
			return psrr_pkg::PID_W'(s + 1);
		endfunction

		// round-robin scan that never picks the idle slot; falls back to it
		function logic pick_next();
			int nxt;
			int s;
			nxt = 0;
			for (int k = 1; k <= psrr_pkg::SLOTS; k++) begin
				s = (cur_slot + k) % psrr_pkg::SLOTS;
				if (s != 0 && slot_st[s] == psrr_pkg::ST_RUN) begin
					nxt = s;
					break;
				end
			end
			if (nxt == cur_slot)
				return 1'b0;
			cur_slot = nxt;
			return 1'b1;
		endfunction

		function void note_request(psrr_pkg::req_t r);
			psrr_pkg::rsp_t e;
			int             hit;
			e = '0;
			e.status = psrr_pkg::STAT_OK;
			hit = psrr_pkg::SLOTS;
			case (r.mode)
				psrr_pkg::MODE_CREATE: begin
					for (int s = 0; s < psrr_pkg::SLOTS; s++)
						if (hit == psrr_pkg::SLOTS && slot_st[s] == psrr_pkg::ST_UNUSED)
							hit = s;
					if (hit == psrr_pkg::SLOTS) begin
						e.status = psrr_pkg::STAT_FULL;
					end else begin
						slot_st[hit] = psrr_pkg::ST_RUN;
						e.new_pid = pid_of(hit);
					end
				end
				psrr_pkg::MODE_EXIT: begin
					slot_st[cur_slot] = psrr_pkg::ST_EXITED;
				end
				psrr_pkg::MODE_YIELD: begin
					e.switched = pick_next();
				end
				default: begin
					for (int s = 0; s < psrr_pkg::SLOTS; s++)
						if (hit == psrr_pkg::SLOTS && slot_st[s] != psrr_pkg::ST_UNUSED
								&& pid_of(s) == r.target_pid)
							hit = s;
					if (hit == psrr_pkg::SLOTS) begin
						e.status = psrr_pkg::STAT_NOTASK;
					end else if (slot_st[hit] == psrr_pkg::ST_EXITED) begin
						slot_st[hit] = psrr_pkg::ST_UNUSED;
					end else begin
						e.switched = pick_next();
						e.status = psrr_pkg::STAT_PENDING;
					end
				end
			endcase
			e.current_pid = pid_of(cur_slot);
			pending_rsp_q.push_back(e);
		endfunction

		function void check_result(psrr_pkg::rsp_t a);
			psrr_pkg::rsp_t e;
			if (pending_rsp_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result with nothing pending: st=%0d new=%0d sw=%0d cur=%0d",
						$realtime, a.status, a.new_pid, a.switched, a.current_pid);
				return;
			end
			e = pending_rsp_q.pop_front();
			if (a.status !== e.status || a.new_pid !== e.new_pid
					|| a.switched !== e.switched || a.current_pid !== e.current_pid) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: mismatch exp st=%0d new=%0d sw=%0d cur=%0d, got st=%0d new=%0d sw=%0d cur=%0d",
						$realtime, e.status, e.new_pid, e.switched, e.current_pid,
						a.status, a.new_pid, a.switched, a.current_pid);
			end
		endfunction

		function int pending();
			return pending_rsp_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	psrr_pkg::req_t req;
	logic done;
	psrr_pkg::rsp_t rsp;

	sched_checker sb = new();
	int burst_left = 0;
	int stall_cycles = 0;

	process_slot_round_robin_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] mode, input logic [psrr_pkg::PID_W-1:0] pid);
		psrr_pkg::req_t r;
		int             gap;
		r.mode = mode;
		r.target_pid = pid;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	task automatic send_random_item();
		int pick;
		logic [1:0] mode;
		logic [psrr_pkg::PID_W-1:0] pid;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			mode = psrr_pkg::MODE_CREATE;
		else if (pick < 45)
			mode = psrr_pkg::MODE_EXIT;
		else if (pick < 72)
			mode = psrr_pkg::MODE_YIELD;
		else
			mode = psrr_pkg::MODE_WAIT;
		// mostly ids that can exist, sometimes any 4-bit value
		if ($urandom_range(0, 9) < 7) begin
			pid = psrr_pkg::PID_W'($urandom_range(0, psrr_pkg::SLOTS - 1));
			if (pid != 0)
				pid = pid + 1'b1;
		end else begin
			pid = psrr_pkg::PID_W'($urandom);
		end
		send_item(mode, pid);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(psrr_pkg::MODE_YIELD, 4'd0);
		send_item(psrr_pkg::MODE_WAIT, 4'd0);
		send_item(psrr_pkg::MODE_WAIT, 4'd15);
		send_item(psrr_pkg::MODE_WAIT, 4'd1);
		// idle slot exits, gets freed and reused with id 0
		send_item(psrr_pkg::MODE_EXIT, 4'd0);
		send_item(psrr_pkg::MODE_WAIT, 4'd0);
		send_item(psrr_pkg::MODE_CREATE, 4'd15);
		for (int i = 0; i < psrr_pkg::SLOTS - 1; i++)
			send_item(psrr_pkg::MODE_CREATE, 4'd0);
		send_item(psrr_pkg::MODE_CREATE, 4'd0);
		send_item(psrr_pkg::MODE_YIELD, 4'd0);
		send_item(psrr_pkg::MODE_EXIT, 4'd0);
		send_item(psrr_pkg::MODE_YIELD, 4'd0);
		send_item(psrr_pkg::MODE_WAIT, 4'd2);
		send_item(psrr_pkg::MODE_WAIT, 4'd4);
		send_item(psrr_pkg::MODE_CREATE, 4'd0);
		send_item(psrr_pkg::MODE_EXIT, 4'd0);
		// current slot freed by wait, then exited again
		send_item(psrr_pkg::MODE_WAIT, 4'd4);
		send_item(psrr_pkg::MODE_EXIT, 4'd0);
		send_item(psrr_pkg::MODE_WAIT, 4'd8);
		send_item(psrr_pkg::MODE_WAIT, 4'd9);

		for (int i = 0; i < 1300; i++)
			send_random_item();

		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> process_slot_round_robin_scheduler.f
hw/rtl/psrr_pkg.sv
hw/rtl/psrr_ctrl.sv
hw/rtl/psrr_dp.sv
hw/rtl/process_slot_round_robin_scheduler.sv
tb/sv/process_slot_round_robin_scheduler_test.sv
